// ===== design/upd_pkg.sv =====
// Shared types, constants and helper functions for the percent decoder.
`default_nettype none
package upd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    // Number of decoded bytes one encoded byte can release.
    localparam int MAX_OUT = 3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    // One queued command: up to three decoded bytes, in order from bytes[0].
    // The last flag applies to the final byte of the command only.
    typedef struct packed {
        logic [1:0]               cnt;
        logic                     last;
        logic [MAX_OUT-1:0][7:0]  bytes;
    } t_cmd;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = ((c >= 8'h30) && (c <= 8'h39)) ||
                 ((c >= 8'h41) && (c <= 8'h46)) ||
                 ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            v = c - 8'h30;
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            v = c - 8'h41 + 8'd10;
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            v = c - 8'h61 + 8'd10;
        end else begin
            v = 8'h00;
        end
        hex_nibble = v[3:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/url_percent_decoder.sv =====
// Top level of the streaming URL percent decoder.
`default_nettype none
// Streaming percent decoder. Encoded text enters one byte per word on the
// input channel, with i_in_last marking the final byte of a string; decoded
// bytes leave one per word on the output channel, with o_out_last on the
// final decoded byte. A percent sign followed by two hex digits (either case)
// becomes one byte, the first digit giving the high nibble. A percent sign
// without a valid pair is passed through literally and the bytes after it
// are scanned again, so a later percent sign can begin a new escape; a
// percent sign in the last two positions of a string passes through. The
// front end classifies each accepted word and, when it releases any bytes,
// queues a command of one to three output bytes; the back end drains the
// queue through a registered output stage at one decoded byte per cycle
// while the receiver is ready. An input word is accepted in every cycle
// while the queue has room, so the sustained rate is one input word per cycle
// as long as each word releases at most one byte and the receiver keeps up;
// a word that flushes two or three bytes holds the output for each of them, and
// QUEUE_DEPTH commands absorb such bursts before the input stalls. Each output
// word passes through the queue, the command register and the output register.
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last
);
    import upd_pkg::*;

    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_head_valid;
    t_cmd  w_cmd;
    t_cmd  w_head;

    // Front end: escape tracking and command building.
    upd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_full     (w_full),
        .o_in_ready (o_in_ready),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    // Command queue decoupling the two sides.
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_data       (w_cmd),
        .i_pop        (w_pop),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // Back end: serializes each command into output words.
    upd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last)
    );

endmodule
`default_nettype wire

// ===== design/upd_front.sv =====
// Front end: accepts encoded words, tracks the escape state and builds output commands.
`default_nettype none
module upd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_in_last,
    input  wire logic          i_full,
    output logic               o_in_ready,
    output logic               o_push,
    output upd_pkg::t_cmd      o_cmd
);
    import upd_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_held;
    logic [7:0] n_held;
    t_cmd       w_cmd;
    logic       w_accept;
    logic       w_b_hex;
    logic       w_starts;

    assign o_in_ready = !i_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_b_hex    = is_hex(i_in_byte);
    // A percent sign opens an escape unless it ends the string.
    assign w_starts   = (i_in_byte == PCT_CHAR) && !i_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'h00;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    always_comb begin
        n_phase    = PH_IDLE;
        n_held     = r_held;
        w_cmd.cnt  = 2'd0;
        w_cmd.last = i_in_last;
        w_cmd.bytes = '0;
        case (r_phase)
            PH_PCT: begin
                if (w_b_hex && !i_in_last) begin
                    n_held  = i_in_byte;
                    n_phase = PH_DIGIT;
                end else if (w_b_hex) begin
                    w_cmd.bytes[0] = PCT_CHAR;
                    w_cmd.bytes[1] = i_in_byte;
                    w_cmd.cnt      = 2'd2;
                end else begin
                    // Broken escape: release the percent sign, then rescan this word.
                    w_cmd.bytes[0] = PCT_CHAR;
                    if (w_starts) begin
                        w_cmd.cnt = 2'd1;
                        n_phase   = PH_PCT;
                    end else begin
                        w_cmd.bytes[1] = i_in_byte;
                        w_cmd.cnt      = 2'd2;
                    end
                end
            end
            PH_DIGIT: begin
                if (w_b_hex && is_hex(r_held)) begin
                    w_cmd.bytes[0] = {hex_nibble(r_held), hex_nibble(i_in_byte)};
                    w_cmd.cnt      = 2'd1;
                end else begin
                    w_cmd.bytes[0] = PCT_CHAR;
                    w_cmd.bytes[1] = r_held;
                    if (w_starts) begin
                        w_cmd.cnt = 2'd2;
                        n_phase   = PH_PCT;
                    end else begin
                        w_cmd.bytes[2] = i_in_byte;
                        w_cmd.cnt      = 2'd3;
                    end
                end
            end
            default: begin
                if (w_starts) begin
                    n_phase = PH_PCT;
                end else begin
                    w_cmd.bytes[0] = i_in_byte;
                    w_cmd.cnt      = 2'd1;
                end
            end
        endcase
    end

    assign o_push = w_accept && (w_cmd.cnt != 2'd0);
    assign o_cmd  = w_cmd;

    a_held_is_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIGIT) |-> is_hex(r_held))
        else $error("held digit is not a hex digit");

    a_last_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_last) |=> (r_phase == PH_IDLE))
        else $error("escape still pending after end of string");

endmodule
`default_nettype wire

// ===== design/upd_queue.sv =====
// Short command queue between the front end and the output serializer.
`default_nettype none
module upd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire upd_pkg::t_cmd i_data,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_head_valid,
    output upd_pkg::t_cmd      o_head
);
    import upd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];
    assign w_push       = i_push && !o_full;
    assign w_pop        = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into a full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== design/upd_back.sv =====
// Back end: takes commands from the queue and sends their bytes out one word at a time.
`default_nettype none
module upd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_head_valid,
    input  wire upd_pkg::t_cmd i_head,
    output logic               o_pop,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_out_last
);
    import upd_pkg::*;

    t_cmd        r_cmd;
    logic        r_have;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        w_load;
    logic        w_final;

    // The output register may take a new word when empty or being drained.
    assign w_load  = !r_out_valid || i_out_ready;
    assign w_final = r_have && (r_idx == (r_cmd.cnt - 2'd1));
    assign o_pop   = i_head_valid && (!r_have || (w_load && w_final));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= r_have;
            end
            if (o_pop) begin
                r_have <= 1'b1;
                r_idx  <= 2'd0;
            end else if (w_load && r_have) begin
                if (w_final) begin
                    r_have <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (w_load && r_have) begin
            r_out_byte <= r_cmd.bytes[r_idx];
            r_out_last <= r_cmd.last && w_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    a_idx_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_idx < r_cmd.cnt))
        else $error("byte index beyond command length");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_head.cnt != 2'd0))
        else $error("empty command taken from queue");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the streaming URL percent decoder.
`timescale 1ns / 100ps

module testbench;
    import upd_pkg::*;

    // If neither channel moves a word for this many cycles, the run is hung.
    // The slowest correct case is a long sender gap followed by a word that
    // releases three bytes into long receiver stalls; this limit leaves a wide
    // margin over that case.
    localparam int WATCHDOG_LIMIT = 2000;
    // Idle cycles after the last expected word, to catch stray output.
    localparam int DRAIN_CYCLES = 12;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    url_percent_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Decoded bytes that the input accepted so far must produce, oldest first.
    logic [7:0] dec_byte_q[$];
    logic       dec_last_q[$];

    // Our own copy of the escape state: the phase and the held first digit.
    t_phase     esc_phase = PH_IDLE;
    logic [7:0] esc_digit = 8'h00;

    // Encoded string that is waiting to be sent, one byte per word.
    logic [7:0] text_q[$];

    int  errors = 0;
    int  words_sent = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    bit  gaps_on = 1'b0;
    bit  stalls_on = 1'b0;
    bit  heavy_stalls = 1'b0;

    logic [7:0] want_byte;
    logic       want_last;

    // Value of an ASCII hex digit in either case, or -1 for any other byte.
    function automatic int digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        return -1;
    endfunction

    // Append one byte to the string that waits to be sent.
    function void append_text(input logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    function void expect_byte(input logic [7:0] b, input logic last);
        dec_byte_q = {dec_byte_q, b};
        dec_last_q = {dec_last_q, last};
    endfunction

    // A byte seen with no escape pending: a percent sign opens an escape
    // unless it ends the string, where it can only pass through.
    function void scan_plain(input logic [7:0] b, input logic last);
        if (b == PCT_CHAR && !last) begin
            esc_phase = PH_PCT;
        end else begin
            expect_byte(b, last);
            esc_phase = PH_IDLE;
        end
    endfunction

    // Advance the escape state by one accepted word and queue the decoded
    // bytes it releases (zero to three of them).
    function void predict_decoded(input logic [7:0] b, input logic last);
        int lo;
        int hi;
        lo = digit_value(b);
        case (esc_phase)
            PH_PCT: begin
                if (lo >= 0 && !last) begin
                    esc_digit = b;
                    esc_phase = PH_DIGIT;
                end else if (lo >= 0) begin
                    // The string ends after one digit: both pass through.
                    expect_byte(PCT_CHAR, 1'b0);
                    expect_byte(b, 1'b1);
                    esc_phase = PH_IDLE;
                end else begin
                    // Broken escape: release the percent sign, rescan the byte.
                    expect_byte(PCT_CHAR, 1'b0);
                    scan_plain(b, last);
                end
            end
            PH_DIGIT: begin
                hi = digit_value(esc_digit);
                if (lo >= 0 && hi >= 0) begin
                    expect_byte({hi[3:0], lo[3:0]}, last);
                    esc_phase = PH_IDLE;
                end else begin
                    expect_byte(PCT_CHAR, 1'b0);
                    expect_byte(esc_digit, 1'b0);
                    scan_plain(b, last);
                end
            end
            default: begin
                scan_plain(b, last);
            end
        endcase
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Random hex digit, letters in either case.
    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'(48 + v);
        if ($urandom_range(0, 1) == 0) return 8'(55 + v);
        return 8'(87 + v);
    endfunction

    // Random byte that is not a hex digit, used to break an escape.
    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (digit_value(c) >= 0) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Offer one word on the input channel and hold it until it is taken.
    // Valid is lowered only when a gap is chosen, so a back-to-back word
    // never sees valid dropped and raised within one time step.
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_decoded(b, last);
        words_sent++;
    endtask

    // Send the buffered text as one string, flagging its final byte.
    task automatic send_text();
        int n;
        n = text_q.size();
        for (int k = 0; k < n; k++) begin
            send_word(text_q[k], k == n - 1);
        end
        text_q.delete();
    endtask

    task automatic add_ascii(input string s);
        for (int k = 0; k < s.len(); k++) append_text(s[k]);
    endtask

    // Build a random string out of pieces. Well-formed escapes are the largest
    // share so that the decode path is exercised often; the rest are stray
    // percent signs, escapes broken after one digit, hex digits and noise.
    // With bursty set, pieces that flush several bytes at once dominate.
    task automatic build_random_text(input bit bursty);
        int pieces;
        int r;
        pieces = $urandom_range(1, 6);
        for (int k = 0; k < pieces; k++) begin
            r = $urandom_range(0, 99);
            if (bursty) r = (r < 60) ? 55 : (r < 80 ? 40 : r);
            if (r < 35) begin
                append_text(PCT_CHAR);
                append_text(rand_hex());
                append_text(rand_hex());
            end else if (r < 50) begin
                append_text(PCT_CHAR);
            end else if (r < 62) begin
                append_text(PCT_CHAR);
                append_text(rand_hex());
                append_text(rand_non_hex());
            end else if (r < 72) begin
                append_text(rand_hex());
            end else begin
                append_text(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic run_random_strings(input int count, input bit bursty);
        int target;
        target = words_sent + count;
        while (words_sent < target) begin
            build_random_text(bursty);
            send_text();
        end
    endtask

    // Hand-picked strings covering each decode rule and the byte extremes.
    task automatic test_directed_cases();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        add_ascii("%4a"); send_text();          // lower-case escape
        add_ascii("%Fa"); send_text();          // mixed case, high nibble F
        append_text(8'h00); send_text();        // lowest byte, passed through
        append_text(8'hFF); send_text();        // highest byte, passed through
        add_ascii("%%41"); send_text();         // percent sign rescanned as escape
        add_ascii("%4G"); send_text();          // broken after one digit
        add_ascii("%4%20"); send_text();        // broken escape reopens one
        add_ascii("%+"); send_text();           // sign instead of a digit
        add_ascii("%a"); send_text();           // string ends after one digit
        add_ascii("%"); send_text();            // lone percent ends the string
    endtask

    // No idling on either side: the decoder must keep pace with the stream.
    task automatic test_full_rate();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        run_random_strings(55, 1'b0);
    endtask

    // Random gaps on the input and random stalls on the output.
    task automatic test_random_idling();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        run_random_strings(90, 1'b0);
    endtask

    // Multi-byte flushes against a slow receiver, so the internal queue
    // fills up and the input has to stall.
    task automatic test_flush_backpressure();
        gaps_on = 1'b0;
        stalls_on = 1'b1;
        heavy_stalls = 1'b1;
        run_random_strings(30, 1'b1);
        heavy_stalls = 1'b0;
    endtask

    // Compare each decoded word against the oldest expectation, then choose
    // whether the receiver stalls next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (dec_byte_q.size() == 0) begin
                $display("%0t: unexpected output word: byte %02h last %0b",
                         $time, o_out_byte, o_out_last);
                errors++;
            end else begin
                want_byte = dec_byte_q.pop_front();
                want_last = dec_last_q.pop_front();
                if (o_out_byte !== want_byte) begin
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, want_byte, o_out_byte);
                    errors++;
                end
                if (o_out_last !== want_last) begin
                    $display("%0t: out_last mismatch: expected %0b, actual %0b",
                             $time, want_last, o_out_last);
                    errors++;
                end
            end
        end
        if (!stalls_on) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 99) < (heavy_stalls ? 70 : 30)) begin
                stall_left = pick_gap();
            end
        end
    end

    // Hang detector: counts cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed_cases();
        test_full_rate();
        test_random_idling();
        test_flush_backpressure();

        // Let the decoder drain, then watch a little longer for stray words.
        i_in_valid <= 1'b0;
        stalls_on = 1'b1;
        while (dec_byte_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
